// ----- design/job_ring_completion_tracker_defines.svh -----
// ----------------------------------------------------------------------------
// Job ring completion tracker assertion macros
// Shared wrappers for the concurrent checks on the tracker's stream ports.
// ----------------------------------------------------------------------------
`ifndef JOB_RING_COMPLETION_TRACKER_DEFINES_SVH
`define JOB_RING_COMPLETION_TRACKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JRCT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define JRCT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/jrct_pkg.sv -----
// ----------------------------------------------------------------------------
// Job ring completion tracker package
// Field widths, stream packing layout and item codes shared by the design.
// ----------------------------------------------------------------------------
package jrct_pkg;

	localparam int KEY_W     = 64;
	localparam int STATUS_W  = 32;
	localparam int OUTCOME_W = 2;
	localparam int FIELD4_W  = 4;

	// Input tdata: desc_address, done_status.
	localparam int IN_DATA_W  = 96;
	// Output tdata: outcome, slot, status_out, retired, in_flight, zero pad.
	localparam int OUT_DATA_W = 48;

	typedef enum logic {
		KIND_SUBMIT   = 1'b0,
		KIND_COMPLETE = 1'b1
	} kind_t;

	typedef enum logic [OUTCOME_W-1:0] {
		OUTCOME_OK       = 2'd0,
		OUTCOME_FULL     = 2'd1,
		OUTCOME_NO_MATCH = 2'd2,
		OUTCOME_EMPTY    = 2'd3
	} outcome_t;

endpackage

// ----- design/job_ring_completion_tracker.sv -----
// ----------------------------------------------------------------------------
// Job ring completion tracker
// A submit, or a completion into an empty ring, goes straight to ST_REPLY.
// Other completions run the serial key compare over 1 to RING_DEPTH-1 slots
// from tail; a match at tail starts the tail walk, which retires each later
// done slot and stops at a pending entry or at head. One item at a time:
// s_tready returns the cycle after the result enters the output register.
// Reset clears the sequencer, head, tail and output valid; the RAM needs none.
// ----------------------------------------------------------------------------
module job_ring_completion_tracker #(
	parameter int RING_DEPTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Input stream. tdata from bit 0: desc_address[63:0], done_status[95:64].
	// tuser: kind (0 submit, 1 completion).
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [jrct_pkg::IN_DATA_W-1:0] s_tdata,
	input  logic                           s_tuser,
	// Output stream. tdata from bit 0: outcome[1:0], slot[5:2],
	// status_out[37:6], retired[41:38], in_flight[45:42], zero pad [47:46].
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [jrct_pkg::OUT_DATA_W-1:0] m_tdata
);

	import jrct_pkg::*;

	localparam int IDX_W = $clog2(RING_DEPTH);
	localparam int ENT_W = KEY_W + 1;

	// The sequencer: one state per phase of an item, one-hot coded.
	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SEARCH = 4'b0010,
		ST_WALK   = 4'b0100,
		ST_REPLY  = 4'b1000
	} state_t;

	state_t state_q;

	// Ring pointers. The ring is a power of two, so they wrap by truncation.
	logic [IDX_W-1:0] head_q;
	logic [IDX_W-1:0] tail_q;

	// Item registers, captured when a transaction is accepted.
	logic [KEY_W-1:0]    key_q;
	logic [STATUS_W-1:0] status_q;
	logic [IDX_W-1:0]    idx_q;
	logic [IDX_W-1:0]    left_q;

	// Result under construction.
	outcome_t            res_outcome_q;
	logic [IDX_W-1:0]    res_slot_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [IDX_W-1:0]    res_retired_q;

	// Output register, so the next item may enter while a result waits.
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	// Each RAM entry holds the job key with its done mark on top. Entries
	// between tail and head were all written by a submit, which clears the
	// mark, so entries outside the ring never need to be cleared.
	logic             ram_wr_en;
	logic [IDX_W-1:0] ram_wr_addr;
	logic [ENT_W-1:0] ram_wr_data;
	logic [IDX_W-1:0] ram_rd_addr;
	logic [ENT_W-1:0] ram_rd_data;

	logic             in_accept;
	kind_t            in_kind;
	logic [IDX_W-1:0] count;
	logic             ring_full;
	logic             key_hit;
	logic             ent_done;
	logic [IDX_W-1:0] tail_next;
	logic             reply_load;
	logic [IDX_W-1:0] in_flight_idx;
	logic [31:0]      slot_wide;
	logic [31:0]      retired_wide;
	logic [31:0]      in_flight_wide;

	assign s_tready  = (state_q == ST_IDLE);
	assign in_accept = s_tvalid && s_tready;
	assign in_kind   = kind_t'(s_tuser);

	assign count     = head_q - tail_q;
	assign ring_full = (count == IDX_W'(RING_DEPTH - 1));
	assign tail_next = tail_q + IDX_W'(1);

	// The shared compare unit: one stored entry against the captured key.
	assign ent_done = ram_rd_data[KEY_W];
	assign key_hit  = !ent_done && (ram_rd_data[KEY_W-1:0] == key_q);

	// The result moves to the output register once that register is free.
	assign reply_load = (state_q == ST_REPLY) && (!out_valid_q || m_tready);

	// RAM write: a submit stores its key with the mark clear; a matched
	// completion rewrites the entry with the mark set.
	always_comb begin
		ram_wr_en   = 1'b0;
		ram_wr_addr = head_q;
		ram_wr_data = {1'b0, s_tdata[KEY_W-1:0]};
		case (state_q)
			ST_IDLE: begin
				ram_wr_en = in_accept && (in_kind == KIND_SUBMIT) && !ring_full;
			end
			ST_SEARCH: begin
				ram_wr_en   = key_hit;
				ram_wr_addr = idx_q;
				ram_wr_data = {1'b1, key_q};
			end
			default: begin
				ram_wr_en = 1'b0;
			end
		endcase
	end

	// RAM read address runs one slot ahead of the entry being examined, so
	// the registered read data lines up with idx_q (search) or tail_q (walk).
	always_comb begin
		case (state_q)
			ST_SEARCH: ram_rd_addr = idx_q + IDX_W'(1);
			ST_WALK:   ram_rd_addr = tail_next;
			default:   ram_rd_addr = tail_q;
		endcase
	end

	jrct_ram #(
		.WIDTH (ENT_W),
		.DEPTH (RING_DEPTH)
	) u_key_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// Sequencer and ring pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						if (in_kind == KIND_SUBMIT) begin
							if (!ring_full) begin
								head_q <= head_q + IDX_W'(1);
							end
							state_q <= ST_REPLY;
						end else if (count == '0) begin
							state_q <= ST_REPLY;
						end else begin
							state_q <= ST_SEARCH;
						end
					end
				end
				ST_SEARCH: begin
					if (key_hit) begin
						// A match at tail retires it at once; the walk then
						// continues over any later entries already done.
						if (idx_q == tail_q) begin
							tail_q  <= tail_next;
							state_q <= (tail_next == head_q) ? ST_REPLY : ST_WALK;
						end else begin
							state_q <= ST_REPLY;
						end
					end else if (left_q == IDX_W'(1)) begin
						state_q <= ST_REPLY;
					end
				end
				ST_WALK: begin
					if (ent_done) begin
						tail_q <= tail_next;
						if (tail_next == head_q) begin
							state_q <= ST_REPLY;
						end
					end else begin
						state_q <= ST_REPLY;
					end
				end
				ST_REPLY: begin
					if (reply_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Item and result registers; these carry data only and need no reset.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					key_q         <= s_tdata[KEY_W-1:0];
					status_q      <= s_tdata[KEY_W +: STATUS_W];
					idx_q         <= tail_q;
					left_q        <= count;
					res_slot_q    <= '0;
					res_status_q  <= '0;
					res_retired_q <= '0;
					if (in_kind == KIND_SUBMIT) begin
						res_outcome_q <= ring_full ? OUTCOME_FULL : OUTCOME_OK;
						if (!ring_full) begin
							res_slot_q <= head_q;
						end
					end else begin
						res_outcome_q <= (count == '0) ? OUTCOME_EMPTY : OUTCOME_OK;
					end
				end
			end
			ST_SEARCH: begin
				if (key_hit) begin
					res_slot_q   <= idx_q;
					res_status_q <= status_q;
					if (idx_q == tail_q) begin
						res_retired_q <= IDX_W'(1);
					end
				end else begin
					idx_q  <= idx_q + IDX_W'(1);
					left_q <= left_q - IDX_W'(1);
					if (left_q == IDX_W'(1)) begin
						res_outcome_q <= OUTCOME_NO_MATCH;
					end
				end
			end
			ST_WALK: begin
				if (ent_done) begin
					res_retired_q <= res_retired_q + IDX_W'(1);
				end
			end
			default: begin
				res_retired_q <= res_retired_q;
			end
		endcase
	end

	// Output fields are four bits wide whatever the ring depth.
	assign in_flight_idx  = head_q - tail_q;
	assign slot_wide      = 32'(res_slot_q);
	assign retired_wide   = 32'(res_retired_q);
	assign in_flight_wide = 32'(in_flight_idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (reply_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (reply_load) begin
			out_data_q <= {2'b00,
				in_flight_wide[FIELD4_W-1:0],
				retired_wide[FIELD4_W-1:0],
				res_status_q,
				slot_wide[FIELD4_W-1:0],
				res_outcome_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

// ----- design/jrct_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module jrct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ----- design/jrct_checker.sv -----
// ----------------------------------------------------------------------------
// Job ring completion tracker checker
// Port-level checks on the tracker's streams, bound to the top level.
// ----------------------------------------------------------------------------
`include "job_ring_completion_tracker_defines.svh"

module jrct_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic [jrct_pkg::IN_DATA_W-1:0]  s_tdata,
	input logic                            s_tuser,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [jrct_pkg::OUT_DATA_W-1:0] m_tdata
);

	import jrct_pkg::*;

	logic not_ok;
	logic is_empty;

	assign not_ok   = m_tdata[OUTCOME_W-1:0] != OUTCOME_OK;
	assign is_empty = m_tdata[OUTCOME_W-1:0] == OUTCOME_EMPTY;

	// A stalled result holds its value.
	`JRCT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

	// Each item is worked on alone: the input closes right after a transaction.
	`JRCT_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "input stayed open after a transaction")

	// A refused item reports no slot, no status and no retirement.
	`JRCT_ASSERT_NOW(a_refused_clean, m_tvalid && not_ok, m_tdata[41:2] == '0, "refused item carries a payload")

	// An empty-ring answer leaves nothing in flight.
	`JRCT_ASSERT_NOW(a_empty_count, m_tvalid && is_empty, m_tdata[45:42] == '0, "empty ring reports jobs in flight")

endmodule

bind job_ring_completion_tracker jrct_checker u_jrct_checker (.*);

// ----- verif/job_ring_completion_tracker_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Job ring completion tracker testbench
// Streams submit and completion transactions into the tracker and checks
// every result against an in-bench model of the ring. A directed opening
// covers the empty, full, unknown-job, duplicate-key and repeated-completion
// cases; random bursts then push the ring between full and empty under
// changing handshake pressure.
// ----------------------------------------------------------------------------
module job_ring_completion_tracker_tb;

	import jrct_pkg::*;

	localparam int RING_SLOTS     = 16;
	localparam int HALF_PERIOD    = 4;
	localparam int RANDOM_JOBS    = 900;
	localparam int RX_HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES   = 64;
	localparam int RUN_LIMIT_NS   = 4_000_000;

	typedef logic [FIELD4_W-1:0] ring_idx_t;

	// One result as the block reports it.
	typedef struct packed {
		outcome_t               outcome;
		ring_idx_t              slot;
		logic [STATUS_W-1:0]    status;
		ring_idx_t              retired;
		ring_idx_t              in_flight;
	} ring_result_t;

	// One transaction waiting to be offered, with the handshake pressure
	// that applies while it is on the bus.
	typedef struct {
		kind_t               kind;
		logic [KEY_W-1:0]    addr;
		logic [STATUS_W-1:0] status;
		int                  tx_gap_pct;
		int                  rx_gap_pct;
		bit                  wait_drain;
		bit                  hold_rx;
	} job_req_t;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata  = '0;
	logic                  s_tuser  = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	job_req_t     pending_jobs[$];
	ring_result_t due_results[$];
	int           jobs_total    = 0;
	int           jobs_accepted = 0;
	int           err_count     = 0;

	// Receiver pressure, set by the driver as each transaction goes out.
	int           rx_gap_pct    = 57;
	logic         hold_pulse    = 1'b0;
	int           hold_cnt      = 0;

	// Stimulus generator settings, copied into each queued transaction.
	int           gen_tx_gap     = 36;
	int           gen_rx_gap     = 57;
	bit           gen_wait_drain = 1'b0;
	bit           gen_hold       = 1'b0;

	// Model of the ring contents.
	logic [KEY_W-1:0] slot_addr[RING_SLOTS];
	logic             slot_finished[RING_SLOTS] = '{default: 1'b0};
	ring_idx_t        ring_head = '0;
	ring_idx_t        ring_tail = '0;

	job_ring_completion_tracker #(
		.RING_DEPTH(RING_SLOTS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#(HALF_PERIOD) clk = 1'b1;
		#(HALF_PERIOD) clk = 1'b0;
	end

	// Applies one transaction to the ring model and returns the result the
	// block must give for it.
	function automatic ring_result_t track_job(input kind_t kind,
			input logic [KEY_W-1:0] addr, input logic [STATUS_W-1:0] status);
		ring_result_t res;
		ring_idx_t    occupied;
		ring_idx_t    idx;
		logic         found;
		int           i;
		res      = '{OUTCOME_OK, '0, '0, '0, '0};
		occupied = ring_head - ring_tail;
		found    = 1'b0;
		idx      = '0;
		if (kind == KIND_SUBMIT) begin
			// One slot always stays free so that head never catches tail.
			if (occupied == ring_idx_t'(RING_SLOTS - 1)) begin
				res.outcome = OUTCOME_FULL;
			end else begin
				slot_addr[ring_head]     = addr;
				slot_finished[ring_head] = 1'b0;
				res.slot                 = ring_head;
				ring_head                = ring_head + ring_idx_t'(1);
			end
		end else if (occupied == 0) begin
			res.outcome = OUTCOME_EMPTY;
		end else begin
			// Oldest pending entry with this address wins; finished ones are skipped.
			for (i = 0; i < occupied && !found; i++) begin
				idx = ring_tail + ring_idx_t'(i);
				if (!slot_finished[idx] && slot_addr[idx] == addr)
					found = 1'b1;
			end
			if (!found) begin
				res.outcome = OUTCOME_NO_MATCH;
			end else begin
				slot_finished[idx] = 1'b1;
				res.slot           = idx;
				res.status         = status;
				while (ring_tail != ring_head && slot_finished[ring_tail]) begin
					slot_finished[ring_tail] = 1'b0;
					ring_tail                = ring_tail + ring_idx_t'(1);
					res.retired              = res.retired + ring_idx_t'(1);
				end
			end
		end
		res.in_flight = ring_head - ring_tail;
		return res;
	endfunction

	function automatic void queue_job(input kind_t kind, input logic [KEY_W-1:0] addr,
			input logic [STATUS_W-1:0] status);
		job_req_t req;
		req.kind       = kind;
		req.addr       = addr;
		req.status     = status;
		req.tx_gap_pct = gen_tx_gap;
		req.rx_gap_pct = gen_rx_gap;
		req.wait_drain = gen_wait_drain;
		req.hold_rx    = gen_hold;
		gen_wait_drain = 1'b0;
		gen_hold       = 1'b0;
		pending_jobs.push_back(req);
	endfunction

	// Three in eight addresses come from tiny pools so duplicates occur.
	function automatic logic [KEY_W-1:0] pick_addr();
		case ($urandom_range(7))
			0, 1: return 64'h0000_0000_8000_0000 + 64'($urandom_range(3) << 6);
			2: return {$urandom_range(1) ? {KEY_W{1'b1}} : {KEY_W{1'b0}}};
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [STATUS_W-1:0] pick_status();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			err_count++;
		end
	endfunction

	// Driver: predicts on every accepted transaction, then offers the next one.
	always @(posedge clk) begin : drive_jobs
		job_req_t req;
		logic     offer;
		logic     hold_now;
		if (!arst_n) begin
			s_tvalid   <= 1'b0;
			hold_pulse <= 1'b0;
		end else begin
			hold_now = 1'b0;
			if (s_tvalid && s_tready) begin
				due_results.push_back(track_job(kind_t'(s_tuser), s_tdata[KEY_W-1:0],
					s_tdata[KEY_W +: STATUS_W]));
				jobs_accepted++;
			end
			if (!s_tvalid || s_tready) begin
				offer = pending_jobs.size() != 0;
				// A drain marker holds the sender back until every result is in.
				if (offer && pending_jobs[0].wait_drain && due_results.size() != 0)
					offer = 1'b0;
				if (offer && $urandom_range(99) < pending_jobs[0].tx_gap_pct)
					offer = 1'b0;
				if (offer) begin
					req = pending_jobs.pop_front();
					s_tdata    <= {req.status, req.addr};
					s_tuser    <= req.kind;
					rx_gap_pct <= req.rx_gap_pct;
					hold_now   = req.hold_rx;
				end
				s_tvalid <= offer;
			end
			hold_pulse <= hold_now;
		end
	end

	// Long receiver hold-off, so the block backs up and stalls its input.
	always @(posedge clk) begin
		if (!arst_n)
			hold_cnt <= 0;
		else if (hold_pulse)
			hold_cnt <= RX_HOLD_CYCLES;
		else if (hold_cnt != 0)
			hold_cnt <= hold_cnt - 1;
	end

	always @(posedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= (hold_cnt == 0) && ($urandom_range(99) >= rx_gap_pct);
	end

	// Monitor: every accepted result is matched against the oldest prediction.
	always @(posedge clk) begin : check_results
		ring_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (due_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual m_tdata %h",
					$time, m_tdata);
				err_count++;
			end else begin
				want = due_results.pop_front();
				check_field("outcome", 32'(want.outcome), 32'(m_tdata[1:0]));
				check_field("slot", 32'(want.slot), 32'(m_tdata[5:2]));
				check_field("status_out", want.status, m_tdata[37:6]);
				check_field("retired", 32'(want.retired), 32'(m_tdata[41:38]));
				check_field("in_flight", 32'(want.in_flight), 32'(m_tdata[45:42]));
			end
		end
	end

	initial begin
		logic [KEY_W-1:0] live_addrs[$];
		logic [KEY_W-1:0] addr;
		logic [KEY_W-1:0] dup_addr;
		int               n;
		int               j;
		int               submit_bias;

		dup_addr    = 64'h5A5A_A5A5_0F0F_F0F0;
		submit_bias = 50;

		// Directed opening. A completion into an empty ring comes first.
		queue_job(KIND_COMPLETE, '1, '1);
		queue_job(KIND_SUBMIT, '0, '1);
		queue_job(KIND_SUBMIT, '1, '0);
		// Two jobs under the same address.
		queue_job(KIND_SUBMIT, dup_addr, $urandom);
		queue_job(KIND_SUBMIT, dup_addr, $urandom);
		// Out of order: the second slot finishes first and nothing retires.
		queue_job(KIND_COMPLETE, '1, '0);
		// The tail slot finishes and the tail walks past both.
		queue_job(KIND_COMPLETE, '0, '1);
		// Same address twice: the older copy matches first, then the newer.
		queue_job(KIND_COMPLETE, dup_addr, 32'h0000_0001);
		queue_job(KIND_COMPLETE, dup_addr, 32'h8000_0000);
		// Fill the ring to its limit of one slot short of the depth.
		for (n = 0; n < RING_SLOTS - 1; n++) begin
			addr = {$urandom, $urandom};
			queue_job(KIND_SUBMIT, addr, $urandom);
			live_addrs.push_back(addr);
		end
		// Unknown job with every entry pending, then a submit into the full ring.
		queue_job(KIND_COMPLETE, dup_addr, $urandom);
		queue_job(KIND_SUBMIT, {$urandom, $urandom}, $urandom);

		// Random bursts: the submit bias moves so the ring swings between full
		// and empty. Most completions name a live job, out of order; some
		// repeat a completion or name an unknown address.
		for (n = 0; n < RANDOM_JOBS; n++) begin
			if (n == RANDOM_JOBS / 3) begin
				gen_tx_gap     = 57;
				gen_rx_gap     = 36;
				gen_wait_drain = 1'b1;
			end
			if (n == 2 * RANDOM_JOBS / 3) begin
				gen_tx_gap = 0;
				gen_rx_gap = 0;
			end
			if (n == 2 * RANDOM_JOBS / 3 + 40)
				gen_hold = 1'b1;
			if (n % 24 == 0)
				submit_bias = $urandom_range(15, 85);
			if ($urandom_range(99) < submit_bias) begin
				addr = pick_addr();
				queue_job(KIND_SUBMIT, addr, pick_status());
				live_addrs.push_back(addr);
				if (live_addrs.size() > 24)
					live_addrs.delete(0);
			end else if (live_addrs.size() != 0 && $urandom_range(9) != 0) begin
				j = $urandom_range(live_addrs.size() - 1);
				queue_job(KIND_COMPLETE, live_addrs[j], pick_status());
				if ($urandom_range(3) != 0)
					live_addrs.delete(j);
			end else begin
				queue_job(KIND_COMPLETE, pick_addr(), pick_status());
			end
		end
		jobs_total = pending_jobs.size();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (jobs_accepted < jobs_total || due_results.size() != 0)
			@(posedge clk);
		// Quiet period to catch any stray result after the last expected one.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("%0t: timeout, %0d of %0d transactions accepted, %0d results outstanding",
			$time, jobs_accepted, jobs_total, due_results.size());
		$display("end of test: mismatches");
		$finish;
	end

endmodule
